[design/vra_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_pkg
// Shared types and constants of the volume reorient address generator.
// ----------------------------------------------------------------------------
package vra_pkg;

    localparam int IDX_W     = 30;
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 3;
    localparam int MAP_W     = 2;
    localparam int FLIP_W    = 3;

    localparam int S_DATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((2 * IDX_W + VALUE_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_Y     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAP_Z     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FLIP_MASK = 3'd6;

    // what the raster counters do after the current voxel
    typedef enum logic [1:0] {
        STEP_X,
        STEP_Y,
        STEP_Z,
        STEP_WRAP
    } step_kind_t;

    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        idx_t [2:0] start;
        idx_t [2:0] step;
        idx_t [2:0] off_init;
        logic       load;
        logic       err;
        logic       clear;
    } addr_cfg_t;

endpackage

[design/vra_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_fifo
// Short register queue between the front and back halves.
// ----------------------------------------------------------------------------
module vra_fifo #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        if (p == AW'(DEPTH - 1))
        begin
            ptr_inc = '0;
        end
        else
        begin
            ptr_inc = p + AW'(1);
        end
    endfunction

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[design/vra_setup.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_setup
// Configuration registers and the stride sequencer: after reset and each
// write to a used register index it works out axis strides, start offsets
// and current offsets with one shared multiplier, one product per cycle.
// ----------------------------------------------------------------------------
module vra_setup
    import vra_pkg::*;
#(
    parameter int MAX_DIM = 1024,
    parameter int CNT_W   = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_idx,
    input  logic [CFG_W-1:0]           cfg_data,
    input  logic [2:0][CNT_W-1:0]      cnt,
    output logic                       busy,
    output logic [2:0][CNT_W-1:0]      szm1,
    output addr_cfg_t                  acfg
);

    localparam int SW    = $clog2(MAX_DIM + 1);
    localparam int CMP_W = (SW > CFG_W) ? SW : CFG_W;
    localparam int PW    = SW + IDX_W;

    localparam logic [2:0] PH_LATCH   = 3'd0;
    localparam logic [2:0] PH_STRIDE  = 3'd1;
    localparam logic [2:0] PH_START_X = 3'd2;
    localparam logic [2:0] PH_START_Y = 3'd3;
    localparam logic [2:0] PH_START_Z = 3'd4;
    localparam logic [2:0] PH_OFF_X   = 3'd5;
    localparam logic [2:0] PH_OFF_Y   = 3'd6;
    localparam logic [2:0] PH_OFF_Z   = 3'd7;

    logic [2:0][CFG_W-1:0] size_reg;
    logic [2:0][MAP_W-1:0] map_reg;
    logic [FLIP_W-1:0]     flip_reg;

    logic                  busy_reg;
    logic                  load_reg;
    logic [2:0]            phase_reg;

    logic [2:0][CNT_W-1:0] szm1_reg;
    logic [1:0][SW-1:0]    cs_reg;
    idx_t                  stride2_reg;
    logic                  err_reg;
    idx_t [2:0]            start_reg;
    idx_t [2:0]            step_reg;
    idx_t [2:0]            off_reg;

    logic                  cfg_hit;
    logic                  size_wr;
    logic [2:0][SW-1:0]    es;
    logic [1:0][SW-1:0]    cs_c;
    logic                  err_c;
    idx_t [2:0]            ax_stride;
    logic [1:0]            ax;
    logic [SW-1:0]         mul_a;
    idx_t                  mul_b;
    logic [PW-1:0]         prod_full;
    idx_t                  prod;

    function automatic logic [SW-1:0] eff_size(input logic [CFG_W-1:0] s);
        logic [CMP_W-1:0] se;
        begin
            se = CMP_W'(s);
            if (s == '0)
            begin
                eff_size = SW'(1);
            end
            else if (se > CMP_W'(MAX_DIM))
            begin
                eff_size = SW'(MAX_DIM);
            end
            else
            begin
                eff_size = SW'(se);
            end
        end
    endfunction

    function automatic idx_t canon_stride(
        input logic [MAP_W-1:0] k,
        input logic [SW-1:0]    cs0,
        input idx_t             s2
    );
        unique case (k)
            2'd1:    canon_stride = IDX_W'(cs0);
            2'd2:    canon_stride = s2;
            default: canon_stride = IDX_W'(1);
        endcase
    endfunction

    assign cfg_hit = cfg_we && (cfg_idx <= REG_FLIP_MASK);
    assign size_wr = cfg_we && (cfg_idx <= REG_SIZE_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= {3{CFG_W'(1)}};
            map_reg  <= {MAP_W'(2), MAP_W'(1), MAP_W'(0)};
            flip_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_SIZE_X:    size_reg[0] <= cfg_data;
                REG_SIZE_Y:    size_reg[1] <= cfg_data;
                REG_SIZE_Z:    size_reg[2] <= cfg_data;
                REG_MAP_X:     map_reg[0]  <= cfg_data[MAP_W-1:0];
                REG_MAP_Y:     map_reg[1]  <= cfg_data[MAP_W-1:0];
                REG_MAP_Z:     map_reg[2]  <= cfg_data[MAP_W-1:0];
                REG_FLIP_MASK: flip_reg    <= cfg_data[FLIP_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            es[i] = eff_size(size_reg[i]);
        end
        err_c = (map_reg[0] > MAP_W'(2)) || (map_reg[1] > MAP_W'(2)) ||
                (map_reg[2] > MAP_W'(2)) || (map_reg[0] == map_reg[1]) ||
                (map_reg[0] == map_reg[2]) || (map_reg[1] == map_reg[2]);
        cs_c = {SW'(1), SW'(1)};
        for (int i = 0; i < 3; i++)
        begin
            if (map_reg[i] == MAP_W'(0))
            begin
                cs_c[0] = es[i];
            end
            if (map_reg[i] == MAP_W'(1))
            begin
                cs_c[1] = es[i];
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            ax_stride[i] = canon_stride(map_reg[i], cs_reg[0], stride2_reg);
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_START_Y, PH_OFF_Y: ax = 2'd1;
            PH_START_Z, PH_OFF_Z: ax = 2'd2;
            default:              ax = 2'd0;
        endcase
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_STRIDE:
            begin
                mul_a = cs_reg[0];
                mul_b = IDX_W'(cs_reg[1]);
            end
            PH_START_X, PH_START_Y, PH_START_Z:
            begin
                mul_a = flip_reg[ax] ? SW'(szm1_reg[ax]) : '0;
                mul_b = ax_stride[ax];
            end
            PH_OFF_X, PH_OFF_Y, PH_OFF_Z:
            begin
                mul_a = flip_reg[ax] ? SW'(szm1_reg[ax] - cnt[ax]) : SW'(cnt[ax]);
                mul_b = ax_stride[ax];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_full = PW'(mul_a) * PW'(mul_b);
    assign prod      = prod_full[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            load_reg  <= 1'b0;
            phase_reg <= PH_LATCH;
        end
        else if (cfg_hit)
        begin
            busy_reg  <= 1'b1;
            load_reg  <= 1'b0;
            phase_reg <= PH_LATCH;
        end
        else if (busy_reg)
        begin
            phase_reg <= phase_reg + 3'd1;
            busy_reg  <= (phase_reg != PH_OFF_Z);
            load_reg  <= (phase_reg == PH_OFF_Z);
        end
        else
        begin
            load_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !cfg_hit)
        begin
            unique case (phase_reg)
                PH_LATCH:
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        szm1_reg[i] <= CNT_W'(es[i] - SW'(1));
                    end
                    cs_reg  <= cs_c;
                    err_reg <= err_c;
                end
                PH_STRIDE:
                begin
                    stride2_reg <= prod;
                end
                PH_START_X, PH_START_Y, PH_START_Z:
                begin
                    start_reg[ax] <= prod;
                    step_reg[ax]  <= flip_reg[ax] ? (IDX_W'(0) - ax_stride[ax])
                                                  : ax_stride[ax];
                end
                default:
                begin
                    off_reg[ax] <= prod;
                end
            endcase
        end
    end

    assign busy          = busy_reg;
    assign szm1          = szm1_reg;
    assign acfg.start    = start_reg;
    assign acfg.step     = step_reg;
    assign acfg.off_init = off_reg;
    assign acfg.load     = load_reg;
    assign acfg.err      = err_reg;
    assign acfg.clear    = size_wr;

endmodule

[design/vra_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_front
// Input side: raster counters, last detection and the step kind of each
// voxel, pushed with its value into the queue.
// ----------------------------------------------------------------------------
module vra_front
    import vra_pkg::*;
#(
    parameter int CNT_W = 10,
    parameter int VW    = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [VW-1:0]         value_in,
    input  logic                  clear,
    input  logic                  busy,
    input  logic [2:0][CNT_W-1:0] szm1,
    output logic [2:0][CNT_W-1:0] cnt,
    input  logic                  q_full,
    output logic                  q_push,
    output step_kind_t            q_kind,
    output logic [VW-1:0]         q_value
);

    logic [2:0][CNT_W-1:0] cnt_reg;
    logic [2:0]            at_end;
    step_kind_t            kind;

    assign s_tready = !busy && !q_full;
    assign q_push   = s_tvalid && s_tready;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            at_end[i] = (cnt_reg[i] == szm1[i]);
        end
        priority if (at_end[0] && at_end[1] && at_end[2])
        begin
            kind = STEP_WRAP;
        end
        else if (at_end[0] && at_end[1])
        begin
            kind = STEP_Z;
        end
        else if (at_end[0])
        begin
            kind = STEP_Y;
        end
        else
        begin
            kind = STEP_X;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (clear)
        begin
            cnt_reg <= '0;
        end
        else if (q_push)
        begin
            unique case (kind)
                STEP_X:
                begin
                    cnt_reg[0] <= cnt_reg[0] + CNT_W'(1);
                end
                STEP_Y:
                begin
                    cnt_reg[0] <= '0;
                    cnt_reg[1] <= cnt_reg[1] + CNT_W'(1);
                end
                STEP_Z:
                begin
                    cnt_reg[0] <= '0;
                    cnt_reg[1] <= '0;
                    cnt_reg[2] <= cnt_reg[2] + CNT_W'(1);
                end
                STEP_WRAP:
                begin
                    cnt_reg <= '0;
                end
            endcase
        end
    end

    assign cnt     = cnt_reg;
    assign q_kind  = kind;
    assign q_value = value_in;

endmodule

[design/vra_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_back
// Output side: per-axis running offsets and the raster index, summed into
// the canonical index and held in the output register.
// ----------------------------------------------------------------------------
module vra_back
    import vra_pkg::*;
#(
    parameter int VW = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  addr_cfg_t     acfg,
    input  logic          q_empty,
    output logic          q_pop,
    input  step_kind_t    q_kind,
    input  logic [VW-1:0] q_value,
    output logic          m_tvalid,
    input  logic          m_tready,
    output idx_t          canon_index,
    output idx_t          raster_index,
    output logic [VW-1:0] value_out,
    output logic          last_voxel,
    output logic          map_error
);

    idx_t [2:0]    off_reg;
    idx_t          raster_reg;
    logic          valid_reg;
    idx_t          canon_out_reg;
    idx_t          raster_out_reg;
    logic [VW-1:0] value_reg;
    logic          last_reg;
    logic          err_reg;
    idx_t          canon_sum;

    assign q_pop     = !q_empty && (!valid_reg || m_tready);
    assign canon_sum = off_reg[0] + off_reg[1] + off_reg[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            raster_reg <= '0;
        end
        else
        begin
            if (q_pop)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
            if (acfg.clear)
            begin
                raster_reg <= '0;
            end
            else if (q_pop)
            begin
                raster_reg <= (q_kind == STEP_WRAP) ? '0 : raster_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (acfg.load)
        begin
            off_reg <= acfg.off_init;
        end
        else if (q_pop)
        begin
            unique case (q_kind)
                STEP_X:
                begin
                    off_reg[0] <= off_reg[0] + acfg.step[0];
                end
                STEP_Y:
                begin
                    off_reg[0] <= acfg.start[0];
                    off_reg[1] <= off_reg[1] + acfg.step[1];
                end
                STEP_Z:
                begin
                    off_reg[0] <= acfg.start[0];
                    off_reg[1] <= acfg.start[1];
                    off_reg[2] <= off_reg[2] + acfg.step[2];
                end
                STEP_WRAP:
                begin
                    off_reg <= acfg.start;
                end
            endcase
        end
        if (q_pop)
        begin
            canon_out_reg  <= acfg.err ? '0 : canon_sum;
            raster_out_reg <= raster_reg;
            value_reg      <= q_value;
            last_reg       <= (q_kind == STEP_WRAP);
            err_reg        <= acfg.err;
        end
    end

    assign m_tvalid     = valid_reg;
    assign canon_index  = canon_out_reg;
    assign raster_index = raster_out_reg;
    assign value_out    = value_reg;
    assign last_voxel   = last_reg;
    assign map_error    = err_reg;

endmodule

[design/volume_reorient_address_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// volume_reorient_address_gen
// Raster-order voxel stream to canonical-volume address pairs.
// ----------------------------------------------------------------------------
// One voxel per cycle: a transaction is taken on every clock while the
// output side keeps up, and its result passes through the queue and the
// output register. The canonical index is kept as three per-axis running
// offsets that step by precomputed signed strides, so no multiply sits in
// the voxel path. After reset and after every write to a used register
// index the setup sequencer builds strides and offsets on its single
// multiplier, with s_tready low, and then loads the offsets.
// Writing a size restarts the raster at voxel 0; map and flip writes keep
// the position. Each result carries the canonical index and the raster
// index, usable as a scatter-write or a gather-read address pair.
// ----------------------------------------------------------------------------
module volume_reorient_address_gen
    import vra_pkg::*;
#(
    parameter int MAX_DIM    = 1024,
    parameter int VALUE_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // voxel_value
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // canon_index, raster_index, value_out
    output logic                 m_tlast,
    output logic [0:0]           m_tuser,   // map_error
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int VW    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int QW    = VW + 2;

    logic                  busy;
    logic [2:0][CNT_W-1:0] szm1;
    logic [2:0][CNT_W-1:0] cnt;
    addr_cfg_t             acfg;

    logic                  q_push;
    logic                  q_full;
    logic                  q_pop;
    logic                  q_empty;
    step_kind_t            push_kind;
    logic [VW-1:0]         push_value;
    logic [QW-1:0]         q_rdata;

    idx_t                  canon_index;
    idx_t                  raster_index;
    logic [VW-1:0]         value_out;
    logic                  last_voxel;
    logic                  map_error;

    vra_setup #(
        .MAX_DIM (MAX_DIM),
        .CNT_W   (CNT_W)
    ) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .cnt      (cnt),
        .busy     (busy),
        .szm1     (szm1),
        .acfg     (acfg)
    );

    vra_front #(
        .CNT_W (CNT_W),
        .VW    (VW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .value_in (s_tdata[VW-1:0]),
        .clear    (acfg.clear),
        .busy     (busy),
        .szm1     (szm1),
        .cnt      (cnt),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_kind   (push_kind),
        .q_value  (push_value)
    );

    vra_fifo #(
        .WIDTH (QW),
        .DEPTH (4)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({push_kind, push_value}),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    vra_back #(
        .VW (VW)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .acfg         (acfg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .q_kind       (step_kind_t'(q_rdata[QW-1:VW])),
        .q_value      (q_rdata[VW-1:0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .canon_index  (canon_index),
        .raster_index (raster_index),
        .value_out    (value_out),
        .last_voxel   (last_voxel),
        .map_error    (map_error)
    );

    assign m_tdata = M_DATA_W'({VALUE_W'(value_out), raster_index, canon_index});
    assign m_tlast = last_voxel;
    assign m_tuser = map_error;

endmodule

[design/vra_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vra_checker
// Port-level assertions for the volume reorient address generator.
// ----------------------------------------------------------------------------
module vra_checker
    import vra_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata,
    input logic                 m_tlast,
    input logic [0:0]           m_tuser,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_idx
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("result changed while stalled");

    // a write to any used register index restarts stride setup and blocks input
    a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && (cfg_idx <= REG_FLIP_MASK) |=> !s_tready)
        else $error("input accepted during stride setup");

    // a bad axis map yields a zero canonical index
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> (m_tdata[IDX_W-1:0] == '0))
        else $error("nonzero canonical index with map error");

endmodule

bind volume_reorient_address_gen vra_checker u_vra_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx)
);

[test/tb_volume_reorient_address_gen.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_volume_reorient_address_gen
// Self-checking bench for the volume reorient address generator.
// ----------------------------------------------------------------------------
// Streams voxels into the block and predicts each canonical index, raster
// index, pass-through value, last flag and map error from a local copy of
// the registers and raster counters. Directed tests cover reset defaults,
// extreme and out-of-range sizes, bad axis maps, the unused register index
// and raster restart on size writes. Random phases then vary the sizes, axis
// maps and flips with random stalls on both sides, and a final phase streams
// with no stalls at all.
// ----------------------------------------------------------------------------
module tb_volume_reorient_address_gen;
    import vra_pkg::*;

    localparam int DIM_LIMIT    = 1024;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct packed {
        idx_t               canon;
        idx_t               raster;
        logic [VALUE_W-1:0] value;
        logic               last_voxel;
        logic               map_err;
    } voxel_addr_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;   // canon_index, raster_index, value_out
    logic                 m_tlast;
    logic [0:0]           m_tuser;   // map_error
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // local copy of registers and raster position
    logic [CFG_W-1:0]     cfg_size [3];
    logic [MAP_W-1:0]     cfg_map  [3];
    logic [FLIP_W-1:0]    cfg_flip;
    longint unsigned      pos_cnt  [3];

    voxel_addr_t          pending_addr_q [$];

    int                   send_idle_pct = 0;
    int                   recv_idle_pct = 0;
    int                   fail_count    = 0;
    int                   cycle_count   = 0;
    int                   voxel_count   = 0;
    int                   write_count   = 0;
    int                   volume_ends   = 0;
    int                   error_voxels  = 0;

    volume_reorient_address_gen u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint unsigned eff_dim(input logic [CFG_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > DIM_LIMIT)
            return DIM_LIMIT;
        return s;
    endfunction

    function automatic void reset_model();
        for (int i = 0; i < 3; i++)
        begin
            cfg_size[i] = CFG_W'(1);
            cfg_map[i]  = MAP_W'(i);
            pos_cnt[i]  = 0;
        end
        cfg_flip = '0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z:
            begin
                cfg_size[idx] = data;
                for (int i = 0; i < 3; i++)
                    pos_cnt[i] = 0;
            end
            REG_MAP_X:     cfg_map[0] = data[MAP_W-1:0];
            REG_MAP_Y:     cfg_map[1] = data[MAP_W-1:0];
            REG_MAP_Z:     cfg_map[2] = data[MAP_W-1:0];
            REG_FLIP_MASK: cfg_flip   = data[FLIP_W-1:0];
            default: ;
        endcase
    endfunction

    // address pair for the voxel at the current raster position; advances it
    function automatic voxel_addr_t reorient_voxel(input logic [VALUE_W-1:0] value);
        voxel_addr_t     r;
        longint unsigned dim   [3];
        longint unsigned csize [3];
        longint unsigned cpos  [3];
        longint unsigned p;
        logic            bad;
        for (int i = 0; i < 3; i++)
            dim[i] = eff_dim(cfg_size[i]);
        bad = cfg_map[0] > 2 || cfg_map[1] > 2 || cfg_map[2] > 2 ||
              cfg_map[0] == cfg_map[1] || cfg_map[0] == cfg_map[2] ||
              cfg_map[1] == cfg_map[2];
        r.canon = '0;
        if (!bad)
        begin
            for (int i = 0; i < 3; i++)
            begin
                p = pos_cnt[i];
                if (cfg_flip[i])
                    p = dim[i] - 1 - p;
                csize[cfg_map[i]] = dim[i];
                cpos[cfg_map[i]]  = p;
            end
            r.canon = idx_t'(cpos[2] * csize[1] * csize[0] + cpos[1] * csize[0] + cpos[0]);
        end
        r.raster = idx_t'(pos_cnt[2] * dim[1] * dim[0] + pos_cnt[1] * dim[0] + pos_cnt[0]);
        r.value  = value;
        r.last_voxel = (pos_cnt[0] + 1 >= dim[0]) && (pos_cnt[1] + 1 >= dim[1]) &&
                       (pos_cnt[2] + 1 >= dim[2]);
        r.map_err = bad;
        if (pos_cnt[0] + 1 < dim[0])
            pos_cnt[0]++;
        else
        begin
            pos_cnt[0] = 0;
            if (pos_cnt[1] + 1 < dim[1])
                pos_cnt[1]++;
            else
            begin
                pos_cnt[1] = 0;
                if (pos_cnt[2] + 1 < dim[2])
                    pos_cnt[2]++;
                else
                    pos_cnt[2] = 0;
            end
        end
        return r;
    endfunction

    // output side: random stall bursts
    always
    begin
        int stall;
        @(negedge clk);
        if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
        begin
            stall = $urandom_range(1, 14);
            m_tready = 1'b0;
            repeat (stall) @(negedge clk);
        end
        m_tready = 1'b1;
    end

    // result checker
    always @(posedge clk)
    begin
        voxel_addr_t exp_addr;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_addr_q.size() == 0)
            begin
                $error("unexpected result transaction, m_tdata=%h", m_tdata);
                fail_count++;
            end
            else
            begin
                exp_addr = pending_addr_q.pop_front();
                if (m_tdata[IDX_W-1:0] !== exp_addr.canon)
                begin
                    $error("canon_index: expected %0d, got %0d",
                           exp_addr.canon, m_tdata[IDX_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[2*IDX_W-1:IDX_W] !== exp_addr.raster)
                begin
                    $error("raster_index: expected %0d, got %0d",
                           exp_addr.raster, m_tdata[2*IDX_W-1:IDX_W]);
                    fail_count++;
                end
                if (m_tdata[2*IDX_W+VALUE_W-1:2*IDX_W] !== exp_addr.value)
                begin
                    $error("value_out: expected %h, got %h",
                           exp_addr.value, m_tdata[2*IDX_W+VALUE_W-1:2*IDX_W]);
                    fail_count++;
                end
                if (m_tlast !== exp_addr.last_voxel)
                begin
                    $error("last_voxel: expected %0b, got %0b", exp_addr.last_voxel, m_tlast);
                    fail_count++;
                end
                if (m_tuser[0] !== exp_addr.map_err)
                begin
                    $error("map_error: expected %0b, got %0b", exp_addr.map_err, m_tuser[0]);
                    fail_count++;
                end
                if (exp_addr.last_voxel)
                    volume_ends++;
                if (exp_addr.map_err)
                    error_voxels++;
            end
        end
    end

    task automatic send_voxel(input logic [VALUE_W-1:0] value);
        int gap;
        @(negedge clk);
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 14);
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = value;
        do
            @(posedge clk);
        while (!s_tready);
        pending_addr_q.push_back(reorient_voxel(value));
        voxel_count++;
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_addr_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data;
        @(negedge clk);
        cfg_we   = 1'b0;
        cfg_data = '0;
        apply_reg(idx, data);
        write_count++;
    endtask

    task automatic set_volume(input int sx, input int sy, input int sz);
        write_reg(REG_SIZE_X, CFG_W'(sx));
        write_reg(REG_SIZE_Y, CFG_W'(sy));
        write_reg(REG_SIZE_Z, CFG_W'(sz));
    endtask

    task automatic set_axes(input int mx, input int my, input int mz, input int flip);
        write_reg(REG_MAP_X, CFG_W'(mx));
        write_reg(REG_MAP_Y, CFG_W'(my));
        write_reg(REG_MAP_Z, CFG_W'(mz));
        write_reg(REG_FLIP_MASK, CFG_W'(flip));
    endtask

    task automatic test_reset_state();
        send_voxel(32'h0000_0000);
        send_voxel(32'hFFFF_FFFF);
        send_voxel(32'h5A5A_A5A5);
        drain_results();
    endtask

    task automatic test_extreme_sizes();
        set_volume(DIM_LIMIT, DIM_LIMIT, DIM_LIMIT);
        write_reg(REG_FLIP_MASK, 11'd7);
        repeat (3) send_voxel($urandom);
        drain_results();
        // oversize and zero sizes clamp
        set_volume(2047, 0, 0);
        write_reg(REG_FLIP_MASK, 11'd1);
        repeat (2) send_voxel($urandom);
        drain_results();
    endtask

    task automatic test_bad_map();
        set_volume(2, 2, 1);
        set_axes(0, 1, 2, 0);
        send_voxel($urandom);
        drain_results();
        write_reg(REG_MAP_X, 11'd3);
        repeat (2) send_voxel($urandom);
        drain_results();
        write_reg(REG_MAP_X, 11'd1);
        send_voxel($urandom);
        drain_results();
        set_axes(2, 0, 1, 6);
        repeat (2) send_voxel($urandom);
        drain_results();
    endtask

    task automatic test_unused_register();
        write_reg(REG_UNUSED, 11'h7FF);
        repeat (2) send_voxel($urandom);
        drain_results();
    endtask

    task automatic test_size_restart();
        set_volume(3, 2, 2);
        set_axes(1, 2, 0, 5);
        repeat (2) send_voxel($urandom);
        // hold off until the pipe is empty, no register change
        drain_results();
        repeat (2) send_voxel($urandom);
        drain_results();
        write_reg(REG_SIZE_Y, 11'd2);
        repeat (3) send_voxel($urandom);
        drain_results();
    endtask

    task automatic randomize_settings();
        logic [CFG_W-1:0] d;
        int               a;
        int               b;
        int               m [3];
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 19))
                    0:       d = '0;
                    1:       d = CFG_W'($urandom_range(DIM_LIMIT + 1, 2047));
                    2:       d = CFG_W'(DIM_LIMIT);
                    default: d = CFG_W'($urandom_range(1, 5));
                endcase
                write_reg(CFG_IDX_W'(REG_SIZE_X + i), d);
            end
        end
        if ($urandom_range(0, 4) != 0)
        begin
            a = $urandom_range(0, 2);
            b = (a + 1 + $urandom_range(0, 1)) % 3;
            m[0] = a;
            m[1] = b;
            m[2] = 3 - a - b;
        end
        else
            for (int i = 0; i < 3; i++)
                m[i] = $urandom_range(0, 3);
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                d = $urandom_range(0, 1) ? CFG_W'($urandom) : '0;
                d[MAP_W-1:0] = MAP_W'(m[i]);
                write_reg(CFG_IDX_W'(REG_MAP_X + i), d);
            end
        end
        if ($urandom_range(0, 1) == 1)
        begin
            d = $urandom_range(0, 1) ? CFG_W'($urandom) : '0;
            d[FLIP_W-1:0] = FLIP_W'($urandom_range(0, 7));
            write_reg(REG_FLIP_MASK, d);
        end
        if ($urandom_range(0, 9) == 0)
            write_reg(REG_UNUSED, CFG_W'($urandom));
    endtask

    task automatic test_random_volumes(input int target);
        int              sent;
        int              n;
        longint unsigned vol;
        sent = 0;
        while (sent < target)
        begin
            randomize_settings();
            case ($urandom_range(0, 2))
                0:       send_idle_pct = 0;
                1:       send_idle_pct = 10;
                default: send_idle_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       recv_idle_pct = 0;
                1:       recv_idle_pct = 5;
                default: recv_idle_pct = 20;
            endcase
            vol = eff_dim(cfg_size[0]) * eff_dim(cfg_size[1]) * eff_dim(cfg_size[2]);
            if (vol <= 30)
                n = int'(vol) * $urandom_range(1, 2) + $urandom_range(0, 3);
            else
                n = $urandom_range(10, 40);
            for (int i = 0; i < n; i++)
            begin
                send_voxel($urandom);
                if (i == n / 2 && $urandom_range(0, 3) == 0)
                    drain_results();
            end
            sent += n;
            drain_results();
        end
    endtask

    task automatic test_steady_stream();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_volume(3, 4, 2);
        set_axes(2, 1, 0, 3);
        repeat (60) send_voxel($urandom);
        drain_results();
    endtask

    initial
    begin
        reset_model();
        send_idle_pct = 20;
        recv_idle_pct = 15;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_state();
        test_extreme_sizes();
        test_bad_map();
        test_unused_register();
        test_size_restart();
        test_random_volumes(300);
        test_steady_stream();

        repeat (8) @(posedge clk);
        $display("Checked %0d voxel transactions across %0d register writes",
                 voxel_count, write_count);
        $display("Volume ends seen: %0d, voxels with bad axis map: %0d",
                 volume_ends, error_voxels);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
